FILE: hw/rtl/cst_pkg.sv
`default_nettype none
package cst_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = 33;
   localparam int MAG_W   = 32;
   localparam int PROD_W  = 64;
   localparam int DPROD_W = 66;
   localparam int AREA_W  = 65;
   localparam int DEN_W   = 66;
   localparam int TERM_W  = 96;
   localparam int SUM_W   = 98;
   localparam int COEF_W  = 32;
   localparam int VAL_W   = 64;
   localparam int DOF_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_D_NORMAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_D_CROSS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_D_SHEAR  = 2'd2;

   localparam logic [COEF_W-1:0] D_NORMAL_RESET = 32'h0001_0000;
   localparam logic [COEF_W-1:0] D_CROSS_RESET  = 32'h0000_0000;
   localparam logic [COEF_W-1:0] D_SHEAR_RESET  = 32'h0000_8000;

   localparam logic [DOF_W-1:0] LAST_DOF = 3'd5;

   localparam logic [VAL_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VAL_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] b_diff;
      logic [2:0][DIFF_W-1:0] c_diff;
      logic [AREA_W-1:0]      area2;
      logic                   degen;
   } cst_tri_type;

   typedef struct packed {
      logic [COEF_W-1:0] d_normal;
      logic [COEF_W-1:0] d_cross;
      logic [COEF_W-1:0] d_shear;
   } cst_coef_type;

   function automatic logic [MAG_W-1:0] diff_mag(logic [DIFF_W-1:0] v);
      logic [DIFF_W-1:0] n;
      n = v[DIFF_W-1] ? (~v + 1'b1) : v;
      return n[MAG_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cst_req_if.sv
`default_nettype none
interface cst_req_if import cst_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] x_a;
   logic [COORD_W-1:0] y_a;
   logic [COORD_W-1:0] x_b;
   logic [COORD_W-1:0] y_b;
   logic [COORD_W-1:0] x_c;
   logic [COORD_W-1:0] y_c;

   modport source (output valid, x_a, y_a, x_b, y_b, x_c, y_c, input ready);
   modport sink   (input valid, x_a, y_a, x_b, y_b, x_c, y_c, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/cst_rsp_if.sv
`default_nettype none
interface cst_rsp_if import cst_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DOF_W-1:0] row_index;
   logic [DOF_W-1:0] col_index;
   logic [VAL_W-1:0] stiffness_value;
   logic             last_entry;
   logic             degenerate;

   modport source (output valid, row_index, col_index, stiffness_value, last_entry,
                   degenerate, input ready);
   modport sink   (input valid, row_index, col_index, stiffness_value, last_entry,
                   degenerate, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/cst_front.sv
`default_nettype none
module cst_front import cst_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   cst_req_if.sink    req_chan,
   output logic       push_valid,
   input  wire logic  push_ready,
   output cst_tri_type push_data
);

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic [2:0][DIFF_W-1:0] b1_ff, c1_ff, b2_ff, c2_ff;
   logic [2:0][DIFF_W-1:0] b_in, c_in;
   logic signed [DPROD_W-1:0] p1_ff, p2_ff, p1_in, p2_in;
   logic signed [DIFF_W-1:0] xa, ya, xb, yb, xc, yc;
   logic signed [DPROD_W:0] det;
   logic [DPROD_W:0] det_mag;
   logic s2_free, s1_free, s1_move, req_take;

   assign s2_free  = !s2_valid_ff || push_ready;
   assign s1_move  = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign req_chan.ready = s1_free;
   assign req_take = req_chan.valid && s1_free;

   assign xa = $signed({req_chan.x_a[COORD_W-1], req_chan.x_a});
   assign ya = $signed({req_chan.y_a[COORD_W-1], req_chan.y_a});
   assign xb = $signed({req_chan.x_b[COORD_W-1], req_chan.x_b});
   assign yb = $signed({req_chan.y_b[COORD_W-1], req_chan.y_b});
   assign xc = $signed({req_chan.x_c[COORD_W-1], req_chan.x_c});
   assign yc = $signed({req_chan.y_c[COORD_W-1], req_chan.y_c});

   always_comb begin
      b_in[0] = yb - yc;
      b_in[1] = yc - ya;
      b_in[2] = ya - yb;
      c_in[0] = xc - xb;
      c_in[1] = xa - xc;
      c_in[2] = xb - xa;
   end

   // twice the signed area is c2*b1 - c1*b2
   assign p1_in = $signed(c1_ff[2]) * $signed(b1_ff[1]);
   assign p2_in = $signed(c1_ff[1]) * $signed(b1_ff[2]);

   assign s1_valid_in = req_take || (s1_valid_ff && !s2_free);
   assign s2_valid_in = s1_move || (s2_valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (req_take) begin
         b1_ff <= b_in;
         c1_ff <= c_in;
      end
      if (s1_move) begin
         b2_ff <= b1_ff;
         c2_ff <= c1_ff;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   assign det     = {p1_ff[DPROD_W-1], p1_ff} - {p2_ff[DPROD_W-1], p2_ff};
   assign det_mag = det[DPROD_W] ? (~det + 1'b1) : det;

   assign push_valid       = s2_valid_ff;
   assign push_data.b_diff = b2_ff;
   assign push_data.c_diff = c2_ff;
   assign push_data.area2  = det_mag[AREA_W-1:0];
   assign push_data.degen  = (det_mag == '0);

endmodule
`default_nettype wire

FILE: hw/rtl/cst_queue.sv
`default_nettype none
module cst_queue import cst_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire cst_tri_type in_data,
   output logic             out_valid,
   input  wire logic        out_pop,
   output cst_tri_type      out_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cst_tri_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = (count_ff != CntW'(Depth));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/cst_back.sv
`default_nettype none
module cst_back import cst_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cst_coef_type coef,
   input  wire logic         tri_valid,
   input  wire cst_tri_type  tri_data,
   output logic              tri_pop,
   cst_rsp_if.source         rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_SUM, ST_ABS, ST_CHK, ST_DIV, ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [DOF_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [PROD_W-1:0] pq1_ff, pq1_in, pq2_ff, pq2_in;
   logic neg1_ff, neg1_in, neg2_ff, neg2_in;
   logic [COEF_W-1:0] k1_ff, k1_in, k2_ff, k2_in;
   logic [PROD_W-1:0] lo1_ff, hi1_ff, lo2_ff, hi2_ff;
   logic [SUM_W-1:0] sum_ff, sum_in, num_ff, num_in;
   logic neg_ff, neg_in, ovf_ff, ovf_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [VAL_W-1:0] nlo_ff, nlo_in, quo_ff, quo_in;
   logic [5:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DOF_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [VAL_W-1:0] rsp_val_ff, val;
   logic rsp_last_ff, rsp_degen_ff;

   logic [1:0] i_sel, j_sel;
   logic [DIFF_W-1:0] bi, bj, ci, cj, op_p1, op_q1, op_p2, op_q2;
   logic [COEF_W-1:0] op_k1, op_k2;
   logic [TERM_W-1:0] t1, t2;
   logic [SUM_W-1:0] s1, s2, smag;
   logic [DEN_W-1:0] den;
   logic [DEN_W:0] shifted;
   logic ge, out_free, is_last, emit;

   assign den = {tri_data.area2, 1'b0};
   assign i_sel = row_ff[2:1];
   assign j_sel = col_ff[2:1];
   assign bi = tri_data.b_diff[i_sel];
   assign bj = tri_data.b_diff[j_sel];
   assign ci = tri_data.c_diff[i_sel];
   assign cj = tri_data.c_diff[j_sel];

   always_comb begin
      unique case ({row_ff[0], col_ff[0]})
         2'b00: begin
            op_p1 = bi; op_q1 = bj; op_k1 = coef.d_normal;
            op_p2 = ci; op_q2 = cj; op_k2 = coef.d_shear;
         end
         2'b01: begin
            op_p1 = bi; op_q1 = cj; op_k1 = coef.d_cross;
            op_p2 = ci; op_q2 = bj; op_k2 = coef.d_shear;
         end
         2'b10: begin
            op_p1 = ci; op_q1 = bj; op_k1 = coef.d_cross;
            op_p2 = bi; op_q2 = cj; op_k2 = coef.d_shear;
         end
         default: begin
            op_p1 = ci; op_q1 = cj; op_k1 = coef.d_normal;
            op_p2 = bi; op_q2 = bj; op_k2 = coef.d_shear;
         end
      endcase
   end

   assign pq1_in  = {32'd0, diff_mag(op_p1)} * {32'd0, diff_mag(op_q1)};
   assign pq2_in  = {32'd0, diff_mag(op_p2)} * {32'd0, diff_mag(op_q2)};
   assign neg1_in = op_p1[DIFF_W-1] ^ op_q1[DIFF_W-1];
   assign neg2_in = op_p2[DIFF_W-1] ^ op_q2[DIFF_W-1];
   assign k1_in   = op_k1;
   assign k2_in   = op_k2;

   assign t1 = {hi1_ff, 32'd0} + {32'd0, lo1_ff};
   assign t2 = {hi2_ff, 32'd0} + {32'd0, lo2_ff};
   assign s1 = neg1_ff ? (~{2'b00, t1} + 1'b1) : {2'b00, t1};
   assign s2 = neg2_ff ? (~{2'b00, t2} + 1'b1) : {2'b00, t2};
   assign sum_in = s1 + s2;

   assign smag   = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign num_in = smag + {{(SUM_W-AREA_W){1'b0}}, tri_data.area2};
   assign neg_in = sum_ff[SUM_W-1];

   assign shifted = {rem_ff, nlo_ff[VAL_W-1]};
   assign ge      = (shifted >= {1'b0, den});

   always_comb begin
      if (tri_data.degen) begin
         val = '0;
      end else if (ovf_ff || quo_ff[VAL_W-1]) begin
         val = neg_ff ? VAL_MIN : VAL_MAX;
      end else begin
         val = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_last  = (row_ff == LAST_DOF) && (col_ff == LAST_DOF);
   assign emit     = (state_ff == ST_EMIT) && out_free;
   assign tri_pop  = emit && is_last;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      ovf_in   = ovf_ff;
      rem_in   = rem_ff;
      nlo_in   = nlo_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (tri_valid) begin
               state_in = tri_data.degen ? ST_EMIT : ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_ABS;
         ST_ABS:  state_in = ST_CHK;
         ST_CHK: begin
            // quotient of 2^64 or more saturates; skip the divide
            ovf_in = ({32'd0, num_ff[SUM_W-1:VAL_W]} >= den);
            rem_in = {32'd0, num_ff[SUM_W-1:VAL_W]};
            nlo_in = num_ff[VAL_W-1:0];
            quo_in = '0;
            cnt_in = 6'd63;
            state_in = ovf_in ? ST_EMIT : ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
            quo_in = {quo_ff[VAL_W-2:0], ge};
            nlo_in = {nlo_ff[VAL_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               if (is_last) begin
                  row_in   = '0;
                  col_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  if (col_ff == LAST_DOF) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
                  state_in = tri_data.degen ? ST_EMIT : ST_MUL1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ovf_ff <= ovf_in;
      rem_ff <= rem_in;
      nlo_ff <= nlo_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (state_ff == ST_MUL1) begin
         pq1_ff  <= pq1_in;
         pq2_ff  <= pq2_in;
         neg1_ff <= neg1_in;
         neg2_ff <= neg2_in;
         k1_ff   <= k1_in;
         k2_ff   <= k2_in;
      end
      if (state_ff == ST_MUL2) begin
         lo1_ff <= {32'd0, pq1_ff[31:0]} * {32'd0, k1_ff};
         hi1_ff <= {32'd0, pq1_ff[63:32]} * {32'd0, k1_ff};
         lo2_ff <= {32'd0, pq2_ff[31:0]} * {32'd0, k2_ff};
         hi2_ff <= {32'd0, pq2_ff[63:32]} * {32'd0, k2_ff};
      end
      if (state_ff == ST_SUM) begin
         sum_ff <= sum_in;
      end
      if (state_ff == ST_ABS) begin
         num_ff <= num_in;
         neg_ff <= neg_in;
      end
      if (emit) begin
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
         rsp_val_ff   <= val;
         rsp_last_ff  <= is_last;
         rsp_degen_ff <= tri_data.degen;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.row_index       = rsp_row_ff;
   assign rsp_chan.col_index       = rsp_col_ff;
   assign rsp_chan.stiffness_value = rsp_val_ff;
   assign rsp_chan.last_entry      = rsp_last_ff;
   assign rsp_chan.degenerate      = rsp_degen_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/cst_triangle_element_stiffness.sv
// Plane-stress stiffness of one linear triangle, unit thickness.
// req_chan carries the three corners (signed Q16.16); rsp_chan returns the
// 36 entries of the 6x6 matrix in row-major order, signed Q48.16, saturated,
// with last_entry on the 36th beat and degenerate on all beats of a
// zero-area triangle (values then zero).
// The front takes one triangle per cycle unless the queue holds it off, and
// registers the coordinate differences and the products for twice the area;
// a queue of QueueDepth triangles follows it. The back computes one entry at
// a time: multiply states ST_MUL1 and ST_MUL2, add states ST_SUM and ST_ABS,
// an overflow check in ST_CHK and a restoring divide in ST_DIV by four times
// the area, skipped on overflow; a degenerate triangle goes straight to
// ST_EMIT. The shared divider serves one entry at a time. A stalled receiver
// holds the output register; the back then waits and the queue and front
// keep taking triangles until full. The D coefficients must be written by
// the user on the csr port while idle; the block does not enforce it. Reset
// clears all valid state and loads d_normal 1.0, d_cross 0, d_shear 0.5.
`default_nettype none
module cst_triangle_element_stiffness import cst_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   cst_req_if.sink                   req_chan,
   cst_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]    csr_wdata
);

   cst_coef_type coef_ff, coef_in;
   logic push_valid, push_ready, tri_valid, tri_pop;
   cst_tri_type push_data, tri_data;

   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_D_NORMAL: coef_in.d_normal = csr_wdata;
            CSR_D_CROSS:  coef_in.d_cross  = csr_wdata;
            CSR_D_SHEAR:  coef_in.d_shear  = csr_wdata;
            default:      coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.d_normal <= D_NORMAL_RESET;
         coef_ff.d_cross  <= D_CROSS_RESET;
         coef_ff.d_shear  <= D_SHEAR_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   cst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   cst_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (tri_valid),
      .out_pop   (tri_pop),
      .out_data  (tri_data)
   );

   cst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_ff),
      .tri_valid (tri_valid),
      .tri_data  (tri_data),
      .tri_pop   (tri_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import cst_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int  QUIET_LIMIT = 20000;
   localparam int  DRAIN_WAIT  = 150;
   localparam int  HOLD_CYCLES = 400;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
   localparam logic [31:0] CMIN = 32'h8000_0000;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [31:0] x_a, y_a, x_b, y_b, x_c, y_c;
      bit          zero_area;   // expected beats typed in: all zero, degenerate set
   } corner_row_type;

   typedef struct {
      logic [DOF_W-1:0] row;
      logic [DOF_W-1:0] col;
      logic [VAL_W-1:0] val;
      bit               last;
      bit               degen;
   } entry_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0]    csr_wdata;

   cst_req_if req_chan ();
   cst_rsp_if rsp_chan ();

   cst_triangle_element_stiffness u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   logic [31:0] d_normal_m, d_cross_m, d_shear_m;
   entry_type   stiff_q[$];
   int          errors = 0;
   int          beats_seen = 0;
   int          tris_sent = 0;
   int          degen_sent = 0;
   int          quiet = 0;
   bit          idle_on = 1'b1;
   bit          hold_req = 1'b0;

   corner_row_type directed[$];

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h (beat %0d)", what, got, want, beats_seen);
      errors++;
   endtask

   function automatic void queue_beat(entry_type e);
      stiff_q.insert(stiff_q.size(), e);
   endfunction

   function automatic void add_row(corner_row_type t);
      directed.insert(directed.size(), t);
   endfunction

   function automatic wide_type coef_term(longint p, longint q, logic [31:0] k);
      return wide_type'(p) * wide_type'(q) * wide_type'({1'b0, k});
   endfunction

   function automatic void push_stiffness(corner_row_type t);
      longint xa, ya, xb, yb, xc, yc;
      longint bd[3], cd[3];
      wide_type det, num;
      logic [127:0] area2, den, mag, q;
      bit degen;
      int i, j;
      entry_type e;
      xa = $signed(t.x_a); ya = $signed(t.y_a);
      xb = $signed(t.x_b); yb = $signed(t.y_b);
      xc = $signed(t.x_c); yc = $signed(t.y_c);
      bd[0] = yb - yc; bd[1] = yc - ya; bd[2] = ya - yb;
      cd[0] = xc - xb; cd[1] = xa - xc; cd[2] = xb - xa;
      det = wide_type'(xb - xa) * wide_type'(yc - ya) - wide_type'(xc - xa) * wide_type'(yb - ya);
      area2 = det < 0 ? -det : det;
      degen = (area2 == 0);
      den = area2 << 1;
      for (int r = 0; r < 6; r++) begin
         for (int c = 0; c < 6; c++) begin
            i = r >> 1;
            j = c >> 1;
            e.row = DOF_W'(r);
            e.col = DOF_W'(c);
            e.last = (r == 5 && c == 5);
            e.degen = degen;
            e.val = '0;
            if (!degen) begin
               if (r % 2 == 0 && c % 2 == 0)
                  num = coef_term(bd[i], bd[j], d_normal_m) + coef_term(cd[i], cd[j], d_shear_m);
               else if (r % 2 == 0)
                  num = coef_term(bd[i], cd[j], d_cross_m) + coef_term(cd[i], bd[j], d_shear_m);
               else if (c % 2 == 0)
                  num = coef_term(cd[i], bd[j], d_cross_m) + coef_term(bd[i], cd[j], d_shear_m);
               else
                  num = coef_term(cd[i], cd[j], d_normal_m) + coef_term(bd[i], bd[j], d_shear_m);
               mag = num < 0 ? -num : num;
               q = (mag + area2) / den;
               if (num < 0)
                  e.val = (q >= 128'h8000_0000_0000_0000) ? VAL_MIN : -q[63:0];
               else
                  e.val = (q > 128'h7FFF_FFFF_FFFF_FFFF) ? VAL_MAX : q[63:0];
            end
            queue_beat(e);
         end
      end
   endfunction

   function automatic void push_zero_area();
      entry_type e;
      for (int k = 0; k < 36; k++) begin
         e.row = DOF_W'(k / 6);
         e.col = DOF_W'(k % 6);
         e.val = '0;
         e.last = (k == 35);
         e.degen = 1'b1;
         queue_beat(e);
      end
   endfunction

   // keep the enable up when another write follows at the next edge
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] data, bit more);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (!more) csr_we <= 1'b0;
      case (idx)
         CSR_D_NORMAL: d_normal_m = data;
         CSR_D_CROSS:  d_cross_m = data;
         CSR_D_SHEAR:  d_shear_m = data;
         default: ;
      endcase
   endtask

   task automatic set_coefs(logic [31:0] dn, logic [31:0] dc, logic [31:0] ds);
      csr_write(CSR_D_NORMAL, dn, 1'b1);
      csr_write(CSR_D_CROSS, dc, 1'b1);
      csr_write(CSR_D_SHEAR, ds, 1'b0);
   endtask

   task automatic send_tri(corner_row_type t);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.x_a <= t.x_a; req_chan.y_a <= t.y_a;
      req_chan.x_b <= t.x_b; req_chan.y_b <= t.y_b;
      req_chan.x_c <= t.x_c; req_chan.y_c <= t.y_c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (t.zero_area) push_zero_area();
      else push_stiffness(t);
      tris_sent++;
      if (t.zero_area) degen_sent++;
   endtask

   // wait for every beat, then let the back end settle before touching the csr
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (stiff_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic corner_row_type mk(logic [31:0] xa, logic [31:0] ya, logic [31:0] xb,
                                         logic [31:0] yb, logic [31:0] xc, logic [31:0] yc,
                                         bit z);
      corner_row_type t;
      t.x_a = xa; t.y_a = ya; t.x_b = xb; t.y_b = yb; t.x_c = xc; t.y_c = yc;
      t.zero_area = z;
      return t;
   endfunction

   function automatic corner_row_type rand_tri(int span);
      corner_row_type t;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         t = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
      end else begin
         t.x_a = $signed($urandom_range(0, 2 * span)) - span;
         t.y_a = $signed($urandom_range(0, 2 * span)) - span;
         t.x_b = $signed($urandom_range(0, 2 * span)) - span;
         t.y_b = $signed($urandom_range(0, 2 * span)) - span;
         t.x_c = $signed($urandom_range(0, 2 * span)) - span;
         t.y_c = $signed($urandom_range(0, 2 * span)) - span;
         t.zero_area = 1'b0;
         if (kind == 1) begin
            // collinear: third corner repeats the first
            t.x_c = t.x_a;
            t.y_c = t.y_a;
         end
      end
      return t;
   endfunction

   // response side: random stalls, one long hold on request
   initial begin
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      entry_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         beats_seen++;
         if (stiff_q.size() == 0) begin
            report("unexpected beat row", 64'(rsp_chan.row_index), 64'd0);
         end else begin
            e = stiff_q.pop_front();
            if (rsp_chan.row_index !== e.row)
               report("row_index", 64'(rsp_chan.row_index), 64'(e.row));
            if (rsp_chan.col_index !== e.col)
               report("col_index", 64'(rsp_chan.col_index), 64'(e.col));
            if (rsp_chan.stiffness_value !== e.val)
               report("stiffness_value", rsp_chan.stiffness_value, e.val);
            if (rsp_chan.last_entry !== e.last)
               report("last_entry", 64'(rsp_chan.last_entry), 64'(e.last));
            if (rsp_chan.degenerate !== e.degen)
               report("degenerate", 64'(rsp_chan.degenerate), 64'(e.degen));
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("timeout with %0d beats outstanding", stiff_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_D_NORMAL;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.x_a <= '0; req_chan.y_a <= '0;
      req_chan.x_b <= '0; req_chan.y_b <= '0;
      req_chan.x_c <= '0; req_chan.y_c <= '0;
      d_normal_m = D_NORMAL_RESET;
      d_cross_m = D_CROSS_RESET;
      d_shear_m = D_SHEAR_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients
      add_row(mk(0, 0, 0, 0, 0, 0, 1'b1));
      add_row(mk(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 1'b1));
      add_row(mk(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 1'b1));
      add_row(mk(0, 0, ONE, 0, 0, ONE, 1'b0));
      add_row(mk(0, 0, 0, ONE, ONE, 0, 1'b0));
      add_row(mk(-ONE, -ONE, 3 * ONE, -2 * ONE, ONE, 5 * ONE, 1'b0));
      add_row(mk(0, 0, 1, 0, 0, 1, 1'b0));
      foreach (directed[k]) send_tri(directed[k]);
      drain();

      // coefficients at their top: saturation on wide triangles
      csr_write(CSR_SPARE, 32'h1234_5678, 1'b1);
      set_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      directed.delete();
      add_row(mk(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, 1'b0));
      add_row(mk(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 1'b0));
      add_row(mk(0, 0, 1, 0, 0, 1, 1'b0));
      add_row(mk(CMIN, 0, CMAX, 1, 0, CMIN, 1'b0));
      add_row(mk(0, 0, ONE, 0, 0, ONE, 1'b0));
      foreach (directed[k]) send_tri(directed[k]);
      drain();

      // all coefficients zero
      set_coefs(0, 0, 0);
      send_tri(mk(0, 0, ONE, 0, 0, ONE, 1'b0));
      send_tri(mk(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, 1'b0));
      drain();

      // fill the block while the receiver holds off
      set_coefs(32'h0002_0000, 32'h0000_8000, 32'h0000_C000);
      hold_req = 1'b1;
      for (int k = 0; k < 8; k++) send_tri(mk(0, 0, 0, 0, 0, 0, 1'b1));
      send_tri(mk(0, 0, ONE, 0, 0, ONE, 1'b0));
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         set_coefs($urandom, $urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0010_0000));
         if (ph == 2) idle_on = 1'b0;
         for (int k = 0; k < 32; k++) send_tri(rand_tri(ph == 0 ? 32'h0000_4000 : 32'h0100_0000));
         drain();
      end

      $display("triangles sent %0d (%0d typed zero-area), beats checked %0d",
               tris_sent, degen_sent, beats_seen);
      $display("coefficient sets: reset, all max, all zero, and random; one long receiver hold");
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire

FILE: cst_triangle_element_stiffness.f
hw/rtl/cst_pkg.sv
hw/rtl/cst_req_if.sv
hw/rtl/cst_rsp_if.sv
hw/rtl/cst_front.sv
hw/rtl/cst_queue.sv
hw/rtl/cst_back.sv
hw/rtl/cst_triangle_element_stiffness.sv
test/tb_top.sv
